>>> rtl/dcrp_pkg.sv
// ----------------------------------------------------------------------------
// dcrp_pkg
// Shared types and constants for the DHCP client reply parser.
// ----------------------------------------------------------------------------
package dcrp_pkg;

	localparam int unsigned MIN_REPLY_BYTES = 240;
	localparam int unsigned MAX_COUNT_BYTES = 2047;
	localparam int unsigned COUNT_W         = 11;

	localparam logic [COUNT_W-1:0] OPTIONS_START = COUNT_W'(240);
	localparam logic [COUNT_W-1:0] POS_OP        = COUNT_W'(0);
	localparam logic [COUNT_W-1:0] POS_XID_END   = COUNT_W'(7);
	localparam logic [COUNT_W-1:0] POS_YI_END    = COUNT_W'(19);
	localparam logic [COUNT_W-1:0] POS_COOKIE_END = COUNT_W'(239);
	localparam logic [COUNT_W-1:0] COUNT_MAX     = COUNT_W'(MAX_COUNT_BYTES);
	localparam logic [COUNT_W-1:0] COUNT_MIN     = COUNT_W'(MIN_REPLY_BYTES);

	localparam logic [31:0] XID_RESET = 32'h1234_5678;
	localparam logic [31:0] COOKIE    = 32'h6382_5363;
	localparam logic [7:0]  OP_REPLY  = 8'd2;

	// option codes
	localparam logic [7:0] OPT_PAD    = 8'd0;
	localparam logic [7:0] OPT_MASK   = 8'd1;
	localparam logic [7:0] OPT_ROUTER = 8'd3;
	localparam logic [7:0] OPT_DNS    = 8'd6;
	localparam logic [7:0] OPT_LEASE  = 8'd51;
	localparam logic [7:0] OPT_TYPE   = 8'd53;
	localparam logic [7:0] OPT_SERVER = 8'd54;
	localparam logic [7:0] OPT_END    = 8'd255;

	// message types
	localparam logic [7:0] MSG_OFFER = 8'd2;
	localparam logic [7:0] MSG_ACK   = 8'd5;
	localparam logic [7:0] MSG_NAK   = 8'd6;

	typedef enum logic [1:0] {
		REQ_BYTE    = 2'd0,
		REQ_START   = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		PH_INIT       = 2'd0,
		PH_SELECTING  = 2'd1,
		PH_REQUESTING = 2'd2,
		PH_BOUND      = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OPH_CODE  = 2'd0,
		OPH_LEN   = 2'd1,
		OPH_VALUE = 2'd2,
		OPH_DONE  = 2'd3
	} opt_phase_t;

	typedef enum logic [2:0] {
		ACT_IGNORED  = 3'd0,
		ACT_DISCOVER = 3'd1,
		ACT_REQUEST  = 3'd2,
		ACT_BOUND    = 3'd3,
		ACT_RESTART  = 3'd4,
		ACT_RELEASED = 3'd5
	} action_t;

	// step control from the top level to the parsing units
	typedef struct packed {
		logic byte_en;
		logic clear;
	} ctl_t;

	typedef struct packed {
		logic [7:0]  kind;
		logic [31:0] mask;
		logic [31:0] router;
		logic [31:0] dns;
		logic [31:0] lease;
		logic [31:0] server;
	} opt_fields_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  message_kind;
		logic [31:0] client_address;
		logic [31:0] server_address;
		logic [31:0] subnet_mask;
		logic [31:0] gateway_address;
		logic [31:0] dns_address;
		logic [31:0] lease_seconds;
		logic [31:0] transaction_out;
		logic        is_bound;
	} result_t;

endpackage

>>> rtl/dcrp_hdr.sv
// ----------------------------------------------------------------------------
// dcrp_hdr
// Byte counter, fixed header checks (op, transaction id, cookie) and yiaddr capture.
// ----------------------------------------------------------------------------
module dcrp_hdr (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dcrp_pkg::ctl_t               ctl,
	input  logic [7:0]                   data_byte,
	input  logic [31:0]                  xid,
	output logic                         in_opts,
	output logic                         len_ok,
	output logic                         hdr_ok_n,
	output logic [31:0]                  yiaddr_n
);

	logic [dcrp_pkg::COUNT_W-1:0] idx_q, idx_n;
	logic                         ok_q;
	logic [31:0]                  shift_q, shift_n;
	logic [31:0]                  yi_q;

	assign in_opts = (idx_q >= dcrp_pkg::OPTIONS_START);

	always_comb begin
		idx_n    = idx_q;
		shift_n  = shift_q;
		hdr_ok_n = ok_q;
		yiaddr_n = yi_q;
		if (ctl.byte_en) begin
			if (idx_q != dcrp_pkg::COUNT_MAX) begin
				idx_n = idx_q + 1'b1;
			end
			if (!in_opts) begin
				shift_n = {shift_q[23:0], data_byte};
				if (idx_q == dcrp_pkg::POS_OP && data_byte != dcrp_pkg::OP_REPLY) begin
					hdr_ok_n = 1'b0;
				end
				if (idx_q == dcrp_pkg::POS_XID_END && shift_n != xid) begin
					hdr_ok_n = 1'b0;
				end
				if (idx_q == dcrp_pkg::POS_YI_END) begin
					yiaddr_n = shift_n;
				end
				if (idx_q == dcrp_pkg::POS_COOKIE_END && shift_n != dcrp_pkg::COOKIE) begin
					hdr_ok_n = 1'b0;
				end
			end
		end
	end

	assign len_ok = (idx_n >= dcrp_pkg::COUNT_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			ok_q    <= 1'b1;
			shift_q <= '0;
			yi_q    <= '0;
		end else if (ctl.clear) begin
			idx_q   <= '0;
			ok_q    <= 1'b1;
			shift_q <= '0;
			yi_q    <= '0;
		end else begin
			idx_q   <= idx_n;
			ok_q    <= hdr_ok_n;
			shift_q <= shift_n;
			yi_q    <= yiaddr_n;
		end
	end

endmodule

>>> rtl/dcrp_opt.sv
// ----------------------------------------------------------------------------
// dcrp_opt
// Option TLV walker; keeps the fields of options that arrived complete.
// ----------------------------------------------------------------------------
module dcrp_opt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dcrp_pkg::ctl_t        ctl,
	input  logic                  in_opts,
	input  logic [7:0]            data_byte,
	output dcrp_pkg::opt_fields_t fields_n
);

	dcrp_pkg::opt_phase_t  ph_q, ph_n;
	logic [7:0]            code_q, code_n;
	logic [7:0]            rem_q, rem_n;
	logic [7:0]            len_q, len_n;
	logic [31:0]           val_q, val_n;
	dcrp_pkg::opt_fields_t fields_q;
	logic                  apply;
	logic                  full;
	logic [7:0]            used;

	always_comb begin
		ph_n   = ph_q;
		code_n = code_q;
		rem_n  = rem_q;
		len_n  = len_q;
		val_n  = val_q;
		apply  = 1'b0;
		used   = len_q - rem_q;
		if (ctl.byte_en && in_opts) begin
			unique case (ph_q)
				dcrp_pkg::OPH_CODE: begin
					if (data_byte == dcrp_pkg::OPT_END) begin
						ph_n = dcrp_pkg::OPH_DONE;
					end else if (data_byte != dcrp_pkg::OPT_PAD) begin
						code_n = data_byte;
						ph_n   = dcrp_pkg::OPH_LEN;
					end
				end
				dcrp_pkg::OPH_LEN: begin
					len_n = data_byte;
					rem_n = data_byte;
					val_n = '0;
					// a zero-length option sets no field
					ph_n  = (data_byte == 8'd0) ? dcrp_pkg::OPH_CODE : dcrp_pkg::OPH_VALUE;
				end
				dcrp_pkg::OPH_VALUE: begin
					if (used < 8'd4) begin
						val_n = {val_q[23:0], data_byte};
					end
					rem_n = rem_q - 8'd1;
					if (rem_n == 8'd0) begin
						apply = 1'b1;
						ph_n  = dcrp_pkg::OPH_CODE;
					end
				end
				dcrp_pkg::OPH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// apply a finished option; value holds at most its first four bytes
	always_comb begin
		fields_n = fields_q;
		full     = (len_q >= 8'd4);
		if (apply) begin
			case (code_q)
				dcrp_pkg::OPT_TYPE: begin
					if (full) begin
						fields_n.kind = val_n[31:24];
					end else begin
						case (len_q[1:0])
							2'd1:    fields_n.kind = val_n[7:0];
							2'd2:    fields_n.kind = val_n[15:8];
							2'd3:    fields_n.kind = val_n[23:16];
							default: fields_n.kind = fields_q.kind;
						endcase
					end
				end
				dcrp_pkg::OPT_MASK:   if (full) fields_n.mask   = val_n;
				dcrp_pkg::OPT_ROUTER: if (full) fields_n.router = val_n;
				dcrp_pkg::OPT_DNS:    if (full) fields_n.dns    = val_n;
				dcrp_pkg::OPT_LEASE:  if (full) fields_n.lease  = val_n;
				dcrp_pkg::OPT_SERVER: if (full) fields_n.server = val_n;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= dcrp_pkg::OPH_CODE;
			code_q   <= '0;
			rem_q    <= '0;
			len_q    <= '0;
			val_q    <= '0;
			fields_q <= '0;
		end else if (ctl.clear) begin
			ph_q     <= dcrp_pkg::OPH_CODE;
			code_q   <= '0;
			rem_q    <= '0;
			len_q    <= '0;
			val_q    <= '0;
			fields_q <= '0;
		end else begin
			ph_q     <= ph_n;
			code_q   <= code_n;
			rem_q    <= rem_n;
			len_q    <= len_n;
			val_q    <= val_n;
			fields_q <= fields_n;
		end
	end

endmodule

>>> rtl/dhcp_client_reply_parser.sv
// ----------------------------------------------------------------------------
// dhcp_client_reply_parser
// DHCP client: start/release events and a streamed reply payload, judged at
// the last byte against the client phase.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid, in_stall | req_type, data_byte, last_byte
//  out     | out_valid, out_stall | action, message_kind, client_address,
//          |                    | server_address, subnet_mask, gateway_address,
//          |                    | dns_address, lease_seconds, transaction_out, is_bound
//
// One word per cycle while in_stall is low: a word is taken into the input
// register, processed once the output register can take it, and its result
// (if any) sits in the output register after; out_valid rises with it.
// in_stall rises only while the output register is full and stalled.
// Reset leaves the client in init with transaction id 0x12345678.
// ----------------------------------------------------------------------------
module dhcp_client_reply_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [7:0]  message_kind,
	output logic [31:0] client_address,
	output logic [31:0] server_address,
	output logic [31:0] subnet_mask,
	output logic [31:0] gateway_address,
	output logic [31:0] dns_address,
	output logic [31:0] lease_seconds,
	output logic [31:0] transaction_out,
	output logic        is_bound
);

	logic                  valid_s1;
	dcrp_pkg::req_t        req_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;

	logic                  out_valid_q;
	dcrp_pkg::result_t     res_q, res_n;
	logic                  res_en;

	dcrp_pkg::phase_t      phase_q, phase_n;
	logic [31:0]           xid_q, xid_n;
	logic                  lease_q, lease_n;

	logic                  advance, go;
	dcrp_pkg::ctl_t        ctl;
	logic                  in_opts, len_ok, hdr_ok_n;
	logic [31:0]           yiaddr_n;
	dcrp_pkg::opt_fields_t fields_n;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign go       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1  <= dcrp_pkg::req_t'(req_type);
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		ctl.byte_en = go && (req_s1 == dcrp_pkg::REQ_BYTE);
		ctl.clear   = go && ((req_s1 == dcrp_pkg::REQ_START) ||
			(req_s1 == dcrp_pkg::REQ_RELEASE) ||
			(req_s1 == dcrp_pkg::REQ_BYTE && last_s1));
	end

	dcrp_hdr u_hdr (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data_byte (byte_s1),
		.xid       (xid_q),
		.in_opts   (in_opts),
		.len_ok    (len_ok),
		.hdr_ok_n  (hdr_ok_n),
		.yiaddr_n  (yiaddr_n)
	);

	dcrp_opt u_opt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.in_opts   (in_opts),
		.data_byte (byte_s1),
		.fields_n  (fields_n)
	);

	// client state and the result word
	always_comb begin
		phase_n = phase_q;
		xid_n   = xid_q;
		lease_n = lease_q;
		res_en  = 1'b0;
		res_n   = '0;
		res_n.action = dcrp_pkg::ACT_IGNORED;
		if (go) begin
			unique case (req_s1)
				dcrp_pkg::REQ_START: begin
					xid_n        = xid_q + 32'd1;
					phase_n      = dcrp_pkg::PH_SELECTING;
					res_n.action = dcrp_pkg::ACT_DISCOVER;
					res_en       = 1'b1;
				end
				dcrp_pkg::REQ_RELEASE: begin
					res_en = 1'b1;
					if (lease_q) begin
						lease_n      = 1'b0;
						phase_n      = dcrp_pkg::PH_INIT;
						res_n.action = dcrp_pkg::ACT_RELEASED;
					end
				end
				dcrp_pkg::REQ_BYTE: begin
					if (last_s1) begin
						res_en = 1'b1;
						if (len_ok && hdr_ok_n) begin
							res_n.message_kind    = fields_n.kind;
							res_n.client_address  = yiaddr_n;
							res_n.server_address  = fields_n.server;
							res_n.subnet_mask     = fields_n.mask;
							res_n.gateway_address = fields_n.router;
							res_n.dns_address     = fields_n.dns;
							res_n.lease_seconds   = fields_n.lease;
							if (fields_n.kind == dcrp_pkg::MSG_OFFER &&
								phase_q == dcrp_pkg::PH_SELECTING) begin
								phase_n      = dcrp_pkg::PH_REQUESTING;
								res_n.action = dcrp_pkg::ACT_REQUEST;
							end else if (fields_n.kind == dcrp_pkg::MSG_ACK &&
								phase_q == dcrp_pkg::PH_REQUESTING) begin
								phase_n      = dcrp_pkg::PH_BOUND;
								lease_n      = 1'b1;
								res_n.action = dcrp_pkg::ACT_BOUND;
							end else if (fields_n.kind == dcrp_pkg::MSG_NAK) begin
								phase_n      = dcrp_pkg::PH_INIT;
								res_n.action = dcrp_pkg::ACT_RESTART;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		res_n.transaction_out = xid_n;
		res_n.is_bound        = (phase_n == dcrp_pkg::PH_BOUND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= dcrp_pkg::PH_INIT;
			xid_q       <= dcrp_pkg::XID_RESET;
			lease_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			xid_q   <= xid_n;
			lease_q <= lease_n;
			if (advance) begin
				out_valid_q <= res_en;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_en) begin
			res_q <= res_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign action          = res_q.action;
	assign message_kind    = res_q.message_kind;
	assign client_address  = res_q.client_address;
	assign server_address  = res_q.server_address;
	assign subnet_mask     = res_q.subnet_mask;
	assign gateway_address = res_q.gateway_address;
	assign dns_address     = res_q.dns_address;
	assign lease_seconds   = res_q.lease_seconds;
	assign transaction_out = res_q.transaction_out;
	assign is_bound        = res_q.is_bound;

endmodule
